// File: rtl/mrc_pkg.sv
// Shared types, constants and CRC helper for the Modbus RTU request checker.
`default_nettype none

package mrc_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGISTER_COUNT = 8'd1;

  localparam logic [15:0] CRC_SEED   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  MIN_FRAME  = 8'd7;
  localparam logic [7:0]  COUNT_MAX  = 8'hFF;

  localparam logic [7:0] FC_READ_COILS     = 8'd1;
  localparam logic [7:0] FC_READ_INPUTS    = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
  localparam logic [7:0] FC_READ_INPUT_REG = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
  localparam logic [7:0] FC_WRITE_REG      = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS     = 8'd16;

  typedef enum logic [2:0] {
    VERDICT_OK          = 3'd0,
    VERDICT_NOT_ADDR    = 3'd1,
    VERDICT_OVERFLOW    = 3'd2,
    VERDICT_TOO_SHORT   = 3'd3,
    VERDICT_BAD_CRC     = 3'd4,
    VERDICT_BAD_FUNC    = 3'd5,
    VERDICT_ADDR_RANGE  = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [15:0] crc;
    logic [7:0]  count;
    logic        overflow;
    logic [7:0]  address;
    logic [7:0]  func;
    logic [15:0] start;
    logic [15:0] quantity;
  } frame_state_t;

  localparam frame_state_t FRAME_CLEAR = '{
    crc: CRC_SEED, count: 8'd0, overflow: 1'b0, address: 8'd0,
    func: 8'd0, start: 16'd0, quantity: 16'd0
  };

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mrc_frame_update.sv
// Per-beat frame state update and end-of-frame verdict logic.
`default_nettype none

module mrc_frame_update
  import mrc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  frame_state_t cur,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   slave_address,
  input  logic [7:0]   register_count,
  output frame_state_t nxt,
  output verdict_t     verdict
);

  localparam logic [7:0] MaxBytes = 8'(MAX_FRAME_BYTES);

  logic [16:0] top_addr;
  logic        func_ok;
  logic        range_chk;

  always_comb begin
    nxt     = cur;
    nxt.crc = crc16_byte(cur.crc, rx_byte);
    case (cur.count)
      8'd0:    nxt.address        = rx_byte;
      8'd1:    nxt.func           = rx_byte;
      8'd2:    nxt.start[15:8]    = rx_byte;
      8'd3:    nxt.start[7:0]     = rx_byte;
      8'd4:    nxt.quantity[15:8] = rx_byte;
      8'd5:    nxt.quantity[7:0]  = rx_byte;
      default: ;
    endcase
    if (cur.count != COUNT_MAX) begin
      nxt.count = cur.count + 8'd1;
    end
    if (nxt.count >= MaxBytes) begin
      nxt.overflow = 1'b1;
    end
  end

  always_comb begin
    func_ok   = nxt.func inside {FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING,
                                 FC_READ_INPUT_REG, FC_WRITE_COIL, FC_WRITE_REG,
                                 FC_WRITE_COILS, FC_WRITE_REGS};
    range_chk = nxt.func inside {FC_READ_HOLDING, FC_READ_INPUT_REG, FC_WRITE_REGS};
    top_addr  = {1'b0, nxt.start} + {1'b0, nxt.quantity};
    if (nxt.address != slave_address) begin
      verdict = VERDICT_NOT_ADDR;
    end else if (nxt.overflow) begin
      verdict = VERDICT_OVERFLOW;
    end else if (nxt.count < MIN_FRAME) begin
      verdict = VERDICT_TOO_SHORT;
    end else if (nxt.crc != 16'd0) begin
      verdict = VERDICT_BAD_CRC;
    end else if (!func_ok) begin
      verdict = VERDICT_BAD_FUNC;
    end else if (range_chk && (top_addr > {9'd0, register_count})) begin
      verdict = VERDICT_ADDR_RANGE;
    end else begin
      verdict = VERDICT_OK;
    end
  end

endmodule

`default_nettype wire

// File: rtl/modbus_rtu_request_checker_top.sv
// Top level of the Modbus RTU slave request checker.
`default_nettype none

// Takes one received byte per beat (tlast marks the last byte of a frame) and
// gives one verdict beat per frame. Throughput is one byte per cycle, but a
// frame's last byte waits while an earlier verdict still holds the output
// register. A byte passes an input register and then the combinational CRC-16
// and header update; at the frame's last byte the verdict goes into the output
// register, which drives out_tvalid. Every checked field comes from the running
// frame state; a frame of MAX_FRAME_BYTES bytes or more for this slave address
// reports overflow. Register writes are taken at any time but belong between frames.
module modbus_rtu_request_checker_top
  import mrc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  // received bytes
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] rx_byte
  input  wire logic                 in_tlast,   // end_of_frame
  // verdicts
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [47:0]               out_tdata,  // [7:0] function_code, [23:8] start_address,
                                                // [39:24] quantity, [47:40] frame_length
  output logic [2:0]                out_tuser   // [2:0] verdict
);

  logic [7:0]   slave_addr_r;
  logic [7:0]   reg_count_r;

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         in_last_r;

  frame_state_t frm_r;
  frame_state_t frm_upd;
  verdict_t     verdict_upd;

  logic         out_valid_r;
  logic [47:0]  out_data_r;
  verdict_t     out_verdict_r;

  logic         out_free;
  logic         s1_adv;
  logic         emit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd1;
      reg_count_r  <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SLAVE_ADDRESS:  slave_addr_r <= cfg_data;
        REG_REGISTER_COUNT: reg_count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = in_valid_r && (!in_last_r || out_free);
  assign emit      = s1_adv && in_last_r;
  assign in_tready = !in_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  mrc_frame_update #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_update (
    .cur            (frm_r),
    .rx_byte        (in_byte_r),
    .slave_address  (slave_addr_r),
    .register_count (reg_count_r),
    .nxt            (frm_upd),
    .verdict        (verdict_upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_r <= FRAME_CLEAR;
    end else if (s1_adv) begin
      frm_r <= in_last_r ? FRAME_CLEAR : frm_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r    <= {frm_upd.count, frm_upd.quantity, frm_upd.start, frm_upd.func};
      out_verdict_r <= verdict_upd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_verdict_r;

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("verdict beat not presented after frame end");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (frm_r.count == 8'd0 && frm_r.crc == CRC_SEED && !frm_r.overflow))
    else $error("frame state not cleared after frame end");

  a_overflow_count: assert property (@(posedge clk) disable iff (!rst_n)
    frm_r.overflow |-> (frm_r.count >= 8'(MAX_FRAME_BYTES)))
    else $error("overflow flag set below frame limit");

  a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r == VERDICT_OK) |-> (out_data_r[47:40] >= MIN_FRAME))
    else $error("ok verdict on a short frame");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !emit)
    else $error("verdict overwritten while stalled");

endmodule

`default_nettype wire
